### hdl/its_pkg.sv
// Package for the idle threshold task scheduler.
// Holds field widths, timing constants, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package its_pkg;

  localparam int unsigned TIME_W     = 62;  // input times and delays
  localparam int unsigned ST_W       = 64;  // internal two's complement times
  localparam int unsigned TMO_W      = 55;  // reported timeout
  localparam int unsigned MASK_W     = 4;   // running and fire masks
  localparam int unsigned CNT_W      = 3;   // action_count register
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 62;
  localparam int unsigned NUM_DLY_REGS = 4;

  localparam logic [ST_W-1:0] NS_PER_SEC   = 64'd1000000000;
  localparam logic [ST_W-1:0] SEC_PER_YEAR = 64'd31536000;
  localparam logic [ST_W-1:0] YEAR_NS_W    = SEC_PER_YEAR * NS_PER_SEC;
  localparam logic [TMO_W-1:0] YEAR_NS     = YEAR_NS_W[TMO_W-1:0];
  localparam logic [TMO_W-1:0] MIN_SLEEP_NS = 55'd10000000;
  localparam logic [ST_W-1:0]  GAP_NS       = 64'd10000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTION_COUNT = 3'd0,
    REG_DELAY_0      = 3'd1,
    REG_DELAY_1      = 3'd2,
    REG_DELAY_2      = 3'd3,
    REG_DELAY_3      = 3'd4
  } its_reg_e;

  typedef enum logic [0:0] {
    REQ_START = 1'b0,
    REQ_EVAL  = 1'b1
  } its_req_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RUN,     // scan running actions for the largest delay
    S_ACT,     // activity = now - idle
    S_CMPWS,   // window start behind running delay?
    S_ORGNOW,  // re-base on running actions
    S_GAPD,    // activity gap
    S_GAPC,    // gap above threshold?
    S_ORGACT,  // re-base on new activity
    S_END,     // window end
    S_FWS,     // fire scan: window start below delay
    S_FEND,    // fire scan: delay reached
    S_FRUN,    // fire scan: track largest fired delay
    S_TWS,     // timeout: distance from window end
    S_TWSC,
    S_TRN,     // timeout: distance from running delay
    S_TRNC,
    S_CLAMP,
    S_DONE
  } its_state_e;

  // Operands of the shared subtract / compare unit
  typedef struct packed {
    logic [ST_W-1:0] a;
    logic [ST_W-1:0] b;
  } its_sub_op_t;

  // a - b with flags
  typedef struct packed {
    logic [ST_W-1:0] diff;
    logic            ult;   // a < b unsigned
    logic            slt;   // a < b signed
    logic            zero;  // a == b
  } its_sub_res_t;

endpackage

`default_nettype wire

### hdl/its_if.sv
// Handshake channels of the idle threshold task scheduler.
// Request, response and configuration write channels; uses its_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface its_req_if;
  import its_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [TIME_W-1:0] now_ns;
  logic [TIME_W-1:0] idle_ns;
  logic              busy_req;
  logic [MASK_W-1:0] running_mask;

  modport source (output valid, req_type, now_ns, idle_ns, busy_req, running_mask,
                  input ready);
  modport sink   (input valid, req_type, now_ns, idle_ns, busy_req, running_mask,
                  output ready);
endinterface

interface its_rsp_if;
  import its_pkg::*;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] fire_mask;
  logic [TMO_W-1:0]  timeout_ns;

  modport source (output valid, fire_mask, timeout_ns, input ready);
  modport sink   (input valid, fire_mask, timeout_ns, output ready);
endinterface

interface its_cfg_if;
  import its_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/its_sub_unit.sv
// Shared 64-bit subtract / compare unit of the scheduler.
// Gives a - b with unsigned, signed and equality flags; uses its_pkg.
`timescale 1ns / 1ps
`default_nettype none

module its_sub_unit (
  input  its_pkg::its_sub_op_t  op_i,
  output its_pkg::its_sub_res_t res_o
);
  import its_pkg::*;

  logic [ST_W:0] diff_ext;

  assign diff_ext   = {1'b0, op_i.a} - {1'b0, op_i.b};
  assign res_o.diff = diff_ext[ST_W-1:0];
  assign res_o.ult  = diff_ext[ST_W];
  // Differing signs decide directly, else the sign of the difference
  assign res_o.slt  = (op_i.a[ST_W-1] ^ op_i.b[ST_W-1]) ? op_i.a[ST_W-1]
                                                          : diff_ext[ST_W-1];
  assign res_o.zero = (diff_ext[ST_W-1:0] == '0);

endmodule

`default_nettype wire

### hdl/its_cfg_regs.sv
// Configuration registers: action count and per-action idle delays.
// Takes write beats from the config channel; uses its_pkg and its_if.
`timescale 1ns / 1ps
`default_nettype none

module its_cfg_regs #(
  parameter int unsigned MAX_ACTIONS = 4
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  its_cfg_if.sink                                   cfg_i,
  output logic [its_pkg::CNT_W-1:0]                 count_o,
  output logic [MAX_ACTIONS-1:0][its_pkg::TIME_W-1:0] dly_o
);
  import its_pkg::*;

  localparam int unsigned NREG = (MAX_ACTIONS < NUM_DLY_REGS) ? MAX_ACTIONS : NUM_DLY_REGS;

  logic [CNT_W-1:0]  count_q;
  logic [TIME_W-1:0] dly_q [NREG];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int k = 0; k < NREG; k++) begin
        dly_q[k] <= '0;
      end
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_ACTION_COUNT) begin
        count_q <= cfg_i.data[CNT_W-1:0];
      end
      for (int k = 0; k < NREG; k++) begin
        if (cfg_i.index == CFG_IDX_W'(int'(REG_DELAY_0) + k)) begin
          dly_q[k] <= cfg_i.data[TIME_W-1:0];
        end
      end
    end
  end

  assign count_o = count_q;

  // Actions without a delay register read as delay zero
  for (genvar j = 0; j < MAX_ACTIONS; j++) begin : g_dly
    if (j < NREG) begin : g_reg
      assign dly_o[j] = dly_q[j];
    end else begin : g_zero
      assign dly_o[j] = '0;
    end
  end

endmodule

`default_nettype wire

### hdl/its_seq.sv
// Sequencer and datapath registers of the scheduler.
// Walks one request through the shared subtract unit; uses its_pkg,
// its_if and its_sub_unit.
`timescale 1ns / 1ps
`default_nettype none

module its_seq #(
  parameter int unsigned MAX_ACTIONS = 4
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  its_req_if.sink                                     req_i,
  input  logic [its_pkg::CNT_W-1:0]                   count_i,
  input  logic [MAX_ACTIONS-1:0][its_pkg::TIME_W-1:0] dly_i,
  input  logic                                        out_free_i,
  output logic                                        emit_o,
  output logic [its_pkg::MASK_W-1:0]                  fire_mask_o,
  output logic [its_pkg::TMO_W-1:0]                   timeout_o
);
  import its_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ACTIONS + 1);
  localparam int unsigned IW = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;

  its_state_e state_q, state_d;
  logic [CW-1:0]          idx_q, idx_d, n_q, n_d, n_cfg;
  logic [ST_W-1:0]        ws_q, ws_d, org_q, org_d, last_q, last_d;
  logic [ST_W-1:0]        act_q, act_d, tmp_q, tmp_d, end_q, end_d;
  logic [TIME_W-1:0]      now_q, now_d, idle_q, idle_d, run_q, run_d;
  logic                   busy_q, busy_d, eval_q, eval_d, flag_q, flag_d;
  logic [MAX_ACTIONS-1:0] rmask_q, rmask_d, fire_q, fire_d, rmask_ext;
  logic [TMO_W-1:0]       tmo_q, tmo_d;
  logic [TIME_W-1:0]      d_cur;
  logic [ST_W-1:0]        d_ext;
  logic                   last_idx;
  its_sub_op_t            op;
  its_sub_res_t           res;

  its_sub_unit u_sub (
    .op_i  (op),
    .res_o (res)
  );

  assign n_cfg    = (int'(count_i) > MAX_ACTIONS) ? CW'(MAX_ACTIONS) : CW'(count_i);
  assign d_cur    = dly_i[idx_q[IW-1:0]];
  assign d_ext    = {{(ST_W-TIME_W){1'b0}}, d_cur};
  assign last_idx = ((idx_q + CW'(1)) == n_q);

  for (genvar j = 0; j < MAX_ACTIONS; j++) begin : g_mask
    if (j < MASK_W) begin : g_in
      assign rmask_ext[j] = req_i.running_mask[j];
      assign fire_mask_o[j] = fire_q[j];
    end else begin : g_none
      assign rmask_ext[j] = 1'b0;
    end
  end
  for (genvar j = MAX_ACTIONS; j < MASK_W; j++) begin : g_pad
    assign fire_mask_o[j] = 1'b0;
  end

  assign timeout_o   = tmo_q;
  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    n_d     = n_q;
    ws_d    = ws_q;
    org_d   = org_q;
    last_d  = last_q;
    act_d   = act_q;
    tmp_d   = tmp_q;
    end_d   = end_q;
    now_d   = now_q;
    idle_d  = idle_q;
    run_d   = run_q;
    busy_d  = busy_q;
    eval_d  = eval_q;
    flag_d  = flag_q;
    rmask_d = rmask_q;
    fire_d  = fire_q;
    tmo_d   = tmo_q;
    op      = '0;
    emit_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          fire_d = '0;
          if (req_i.req_type == REQ_START) begin
            ws_d    = '0;
            org_d   = {{(ST_W-TIME_W){1'b0}}, req_i.now_ns};
            last_d  = {{(ST_W-TIME_W){1'b0}}, req_i.now_ns};
            tmo_d   = '0;
            eval_d  = 1'b0;
            state_d = S_DONE;
          end else begin
            now_d   = req_i.now_ns;
            idle_d  = req_i.busy_req ? '0 : req_i.idle_ns;
            busy_d  = req_i.busy_req;
            rmask_d = rmask_ext;
            n_d     = n_cfg;
            idx_d   = '0;
            run_d   = '0;
            eval_d  = 1'b1;
            state_d = (n_cfg == '0) ? S_ACT : S_RUN;
          end
        end
      end
      S_RUN: begin
        op.a = {{(ST_W-TIME_W){1'b0}}, run_q};
        op.b = d_ext;
        if (rmask_q[idx_q[IW-1:0]] && res.slt) begin
          run_d = d_cur;
        end
        if (last_idx) begin
          idx_d   = '0;
          state_d = S_ACT;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      S_ACT: begin
        op.a    = {{(ST_W-TIME_W){1'b0}}, now_q};
        op.b    = {{(ST_W-TIME_W){1'b0}}, idle_q};
        act_d   = res.diff;
        state_d = S_CMPWS;
      end
      S_CMPWS: begin
        op.a = ws_q;
        op.b = {{(ST_W-TIME_W){1'b0}}, run_q};
        if (res.slt) begin
          ws_d    = {{(ST_W-TIME_W){1'b0}}, run_q};
          state_d = S_ORGNOW;
        end else begin
          state_d = S_GAPD;
        end
      end
      S_ORGNOW: begin
        op.a    = {{(ST_W-TIME_W){1'b0}}, now_q};
        op.b    = {{(ST_W-TIME_W){1'b0}}, run_q};
        org_d   = res.diff;
        act_d   = {{(ST_W-TIME_W){1'b0}}, now_q};
        state_d = S_END;
      end
      S_GAPD: begin
        op.a    = act_q;
        op.b    = last_q;
        tmp_d   = res.diff;
        state_d = S_GAPC;
      end
      S_GAPC: begin
        op.a = GAP_NS;
        op.b = tmp_q;
        if (res.slt) begin
          ws_d    = {{(ST_W-TIME_W){1'b0}}, run_q};
          state_d = S_ORGACT;
        end else begin
          state_d = S_END;
        end
      end
      S_ORGACT: begin
        op.a    = act_q;
        op.b    = {{(ST_W-TIME_W){1'b0}}, run_q};
        org_d   = res.diff;
        state_d = S_END;
      end
      S_END: begin
        op.a   = {{(ST_W-TIME_W){1'b0}}, now_q};
        op.b   = org_q;
        end_d  = res.diff;
        last_d = act_q;
        tmo_d  = YEAR_NS;
        idx_d  = '0;
        if (n_q == '0) begin
          ws_d    = res.diff;
          state_d = S_CLAMP;
        end else begin
          state_d = S_FWS;
        end
      end
      S_FWS: begin
        op.a    = d_ext;
        op.b    = ws_q;
        flag_d  = !res.slt && !res.zero;
        state_d = S_FEND;
      end
      S_FEND, S_FRUN: begin
        if (state_q == S_FEND) begin
          op.a = end_q;
          op.b = d_ext;
        end else begin
          op.a = {{(ST_W-TIME_W){1'b0}}, run_q};
          op.b = d_ext;
          if (res.slt) begin
            run_d = d_cur;
          end
        end
        if (state_q == S_FEND && flag_q && !res.slt) begin
          fire_d[idx_q[IW-1:0]] = 1'b1;
          state_d = S_FRUN;
        end else if (last_idx) begin
          // Close the window at its end and move to the timeout scan, or to the clamp when busy
          ws_d    = end_q;
          idx_d   = '0;
          state_d = busy_q ? S_CLAMP : S_TWS;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_FWS;
        end
      end
      S_TWS, S_TRN: begin
        op.a    = d_ext;
        op.b    = (state_q == S_TWS) ? ws_q : {{(ST_W-TIME_W){1'b0}}, run_q};
        flag_d  = !res.slt && !res.zero;
        tmp_d   = res.diff;
        state_d = (state_q == S_TWS) ? S_TWSC : S_TRNC;
      end
      S_TWSC, S_TRNC: begin
        op.a = tmp_q;
        op.b = {{(ST_W-TMO_W){1'b0}}, tmo_q};
        if (flag_q && res.ult) begin
          tmo_d = tmp_q[TMO_W-1:0];
        end
        if (state_q == S_TWSC) begin
          state_d = S_TRN;
        end else if (last_idx) begin
          state_d = S_CLAMP;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_TWS;
        end
      end
      S_CLAMP: begin
        op.a = {{(ST_W-TMO_W){1'b0}}, tmo_q};
        op.b = {{(ST_W-TMO_W){1'b0}}, MIN_SLEEP_NS};
        if (res.ult) begin
          tmo_d = MIN_SLEEP_NS;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      n_q     <= '0;
      ws_q    <= '0;
      org_q   <= '0;
      last_q  <= '0;
      eval_q  <= 1'b0;
      busy_q  <= 1'b0;
      fire_q  <= '0;
      tmo_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      ws_q    <= ws_d;
      org_q   <= org_d;
      last_q  <= last_d;
      eval_q  <= eval_d;
      busy_q  <= busy_d;
      fire_q  <= fire_d;
      tmo_q   <= tmo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    tmp_q   <= tmp_d;
    end_q   <= end_d;
    now_q   <= now_d;
    idle_q  <= idle_d;
    run_q   <= run_d;
    flag_q  <= flag_d;
    rmask_q <= rmask_d;
  end

  // Timeout lies in range after an evaluation; timeout and fire mask are zero after a start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> (!eval_q && tmo_q == '0 && fire_q == '0) ||
               (eval_q && tmo_q >= MIN_SLEEP_NS && tmo_q <= YEAR_NS))
    else $error("timeout out of range at result");

  // A busy evaluation always sleeps one year
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o && eval_q && busy_q |-> tmo_q == YEAR_NS)
    else $error("busy evaluation without one-year timeout");

  // Only actions below the count can fire
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o && eval_q |-> (fire_q >> n_q) == '0)
    else $error("fire beyond action count");

  // Scan index stays below the action count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN || state_q == S_FWS || state_q == S_FEND || state_q == S_FRUN ||
     state_q == S_TWS || state_q == S_TWSC || state_q == S_TRN || state_q == S_TRNC)
    |-> idx_q < n_q)
    else $error("scan index past action count");

endmodule

`default_nettype wire

### hdl/idle_threshold_task_scheduler.sv
// Top level of the idle threshold task scheduler.
// Ties config registers, sequencer and response register together;
// uses its_pkg, its_if, its_cfg_regs and its_seq.
//
//   channel | dir | handshake    | payload
//   --------+-----+--------------+-------------------------------------------
//   req_i   | in  | valid/ready  | req_type, now_ns, idle_ns, busy_req,
//           |     |              | running_mask
//   rsp_o   | out | valid/ready  | fire_mask, timeout_ns
//   cfg_i   | in  | valid/ready  | index (0 count, 1..4 delays), data
//
// Every step of an evaluate beat goes through the one 64-bit subtract/compare
// unit, one step per cycle, and the result waits in the done state until the
// response slot is free.
// The request side is ready only while the sequencer is idle; the response
// register holds a finished result while the next request is worked on.
// Reset clears all timeline state and config registers; no clearing pass.
// Config beats are always taken and written straight into the registers.
`timescale 1ns / 1ps
`default_nettype none

module idle_threshold_task_scheduler #(
  parameter int unsigned MAX_ACTIONS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  its_req_if.sink   req_i,
  its_rsp_if.source rsp_o,
  its_cfg_if.sink   cfg_i
);
  import its_pkg::*;

  logic [CNT_W-1:0]                   count;
  logic [MAX_ACTIONS-1:0][TIME_W-1:0] dly;
  logic                               emit;
  logic                               out_free;
  logic [MASK_W-1:0]                  seq_fire;
  logic [TMO_W-1:0]                   seq_tmo;

  logic              rsp_valid_q;
  logic [MASK_W-1:0] rsp_fire_q;
  logic [TMO_W-1:0]  rsp_tmo_q;

  its_cfg_regs #(
    .MAX_ACTIONS (MAX_ACTIONS)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .count_o (count),
    .dly_o   (dly)
  );

  its_seq #(
    .MAX_ACTIONS (MAX_ACTIONS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .count_i     (count),
    .dly_i       (dly),
    .out_free_i  (out_free),
    .emit_o      (emit),
    .fire_mask_o (seq_fire),
    .timeout_o   (seq_tmo)
  );

  // The slot is free when empty or when its beat leaves this cycle
  assign out_free = !rsp_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (emit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // Load the payload only with a new result, hold it otherwise
  always_ff @(posedge clk_i) begin
    if (emit) begin
      rsp_fire_q <= seq_fire;
      rsp_tmo_q  <= seq_tmo;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.fire_mask  = rsp_fire_q;
  assign rsp_o.timeout_ns = rsp_tmo_q;

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking bench for the idle threshold task scheduler.
// Drives the request, config and response channels and checks each response beat
// against an in-bench schedule predictor. Depends on its_pkg, its_if and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import its_pkg::*;

  localparam int unsigned SLOTS        = 4;       // MAX_ACTIONS of the instance
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned SETTLE_CYCLES = 60;     // beyond the evaluate worst case
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS  = 48;

  localparam logic [TIME_W-1:0] MAX_T  = '1;
  localparam logic [TIME_W-1:0] ONE_MS = 62'd1000000;
  localparam logic [TIME_W-1:0] ONE_S  = 62'd1000000000;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // One line of stimulus: either a config write or a request beat. Rows with
  // typed set carry their own expected response.
  typedef struct {
    row_kind_e         kind;
    its_reg_e          reg_idx;
    logic [TIME_W-1:0] data;
    its_req_e          op;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] idle;
    logic              busy;
    logic [MASK_W-1:0] run;
    logic              typed;
    logic [MASK_W-1:0] fire;
    logic [TMO_W-1:0]  tmo;
  } stim_row_t;

  typedef struct packed {
    logic [MASK_W-1:0] fire;
    logic [TMO_W-1:0]  tmo;
  } sched_out_t;

  logic clk_i;
  logic rst_ni;

  its_req_if req_ch ();
  its_rsp_if rsp_ch ();
  its_cfg_if cfg_ch ();

  idle_threshold_task_scheduler #(
    .MAX_ACTIONS(SLOTS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch),
    .cfg_i (cfg_ch)
  );

  // Predictor state: shadow config and timeline
  logic [CNT_W-1:0]  act_count;
  logic [TIME_W-1:0] dly [SLOTS];
  logic [ST_W-1:0]   win_start;
  logic [ST_W-1:0]   origin;
  logic [ST_W-1:0]   prev_activity;

  sched_out_t pending_out[$];   // responses still owed by the block
  stim_row_t  dir_tab[$];

  int unsigned err_count;
  int unsigned n_items;
  int unsigned n_fired;
  int unsigned n_checked;
  int unsigned n_cfg;
  int unsigned cyc;
  int unsigned stall_left;
  logic        calm;            // no idling on either side while set

  // Random-walk timeline for well-formed evaluation sequences
  logic [TIME_W-1:0] tl_now;
  logic [TIME_W-1:0] tl_input;

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d responses outstanding", $time, pending_out.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [TIME_W-1:0] rand62();
    return TIME_W'({$urandom, $urandom});
  endfunction

  // Idle length for either side: mostly none or short, a few long
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (calm || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic stim_row_t mk_req(its_req_e op, logic [TIME_W-1:0] now,
                                       logic [TIME_W-1:0] idle, logic busy,
                                       logic [MASK_W-1:0] run, logic typed,
                                       logic [MASK_W-1:0] fire, logic [TMO_W-1:0] tmo);
    stim_row_t r;
    r.kind    = ROW_REQ;
    r.reg_idx = REG_ACTION_COUNT;
    r.data    = '0;
    r.op      = op;
    r.now     = now;
    r.idle    = idle;
    r.busy    = busy;
    r.run     = run;
    r.typed   = typed;
    r.fire    = fire;
    r.tmo     = tmo;
    return r;
  endfunction

  function automatic stim_row_t mk_cfg(its_reg_e idx, logic [TIME_W-1:0] data);
    stim_row_t r;
    r         = mk_req(REQ_START, '0, '0, 1'b0, '0, 1'b0, '0, '0);
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.data    = data;
    return r;
  endfunction

  // Schedule predictor: advance the shadow timeline by one request and
  // return the response it calls for.
  function automatic sched_out_t step_schedule(stim_row_t r);
    logic [ST_W-1:0]   now, idle, running, activity, gap, win_end, tmo, dly_i;
    logic [MASK_W-1:0] fire;
    int                n;
    sched_out_t        res;
    now  = {2'b00, r.now};
    idle = {2'b00, r.idle};
    fire = '0;
    res  = '0;
    // Start: new origin, nothing fires, zero timeout
    if (r.op == REQ_START) begin
      win_start     = '0;
      origin        = now;
      prev_activity = now;
      return res;
    end
    n = (act_count > SLOTS) ? SLOTS : int'(act_count);
    // Largest delay among actions still running
    running = '0;
    for (int i = 0; i < n; i++) begin
      dly_i = {2'b00, dly[i]};
      if (r.run[i] && $signed(running) < $signed(dly_i)) running = dly_i;
    end
    if (r.busy) idle = '0;
    activity = now - idle;
    gap      = activity - prev_activity;
    // Re-base on running actions first, else on fresh activity past the gap
    if ($signed(win_start) < $signed(running)) begin
      win_start = running;
      origin    = now - running;
      activity  = now;
    end else if ($signed(GAP_NS) < $signed(gap)) begin
      win_start = running;
      origin    = activity - running;
    end
    prev_activity = activity;
    win_end  = now - origin;
    // Fire every delay in (win_start, win_end]
    for (int i = 0; i < n; i++) begin
      dly_i = {2'b00, dly[i]};
      if ($signed(win_start) < $signed(dly_i) && !($signed(win_end) < $signed(dly_i))) begin
        fire[i] = 1'b1;
        if ($signed(running) < $signed(dly_i)) running = dly_i;
      end
    end
    win_start = win_end;
    // Next wake-up: nearest delay ahead of the window or the running set
    tmo = YEAR_NS_W;
    if (!r.busy) begin
      for (int i = 0; i < n; i++) begin
        dly_i = {2'b00, dly[i]};
        if ($signed(win_start) < $signed(dly_i) && (dly_i - win_start) < tmo)
          tmo = dly_i - win_start;
        if ($signed(running) < $signed(dly_i) && (dly_i - running) < tmo)
          tmo = dly_i - running;
      end
      if (tmo < ST_W'(MIN_SLEEP_NS)) tmo = ST_W'(MIN_SLEEP_NS);
    end
    res.fire = fire;
    res.tmo  = tmo[TMO_W-1:0];
    return res;
  endfunction

  // Present one request beat, hold it until taken, then log the expected
  // response. Called and returns in a falling-edge time step.
  task automatic send_req(stim_row_t r);
    int unsigned gap;
    sched_out_t  exp_out;
    gap = gap_len();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= r.op;
    req_ch.now_ns       <= r.now;
    req_ch.idle_ns      <= r.idle;
    req_ch.busy_req     <= r.busy;
    req_ch.running_mask <= r.run;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    exp_out = step_schedule(r);
    if (r.typed) begin
      exp_out.fire = r.fire;
      exp_out.tmo  = r.tmo;
    end
    pending_out.push_back(exp_out);
    n_items++;
    @(negedge clk_i);
  endtask

  // Wait out every owed response plus the block's own settle time; lower
  // valid first so the next beat starts clean.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // One config beat; only issued with the block idle.
  task automatic write_reg(its_reg_e idx, logic [TIME_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    case (idx)
      REG_ACTION_COUNT: act_count = data[CNT_W-1:0];
      REG_DELAY_0:      dly[0] = data;
      REG_DELAY_1:      dly[1] = data;
      REG_DELAY_2:      dly[2] = data;
      REG_DELAY_3:      dly[3] = data;
      default: ;
    endcase
    n_cfg++;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Delay values: mostly within ten seconds, some at the extremes
  function automatic logic [TIME_W-1:0] rand_delay();
    int unsigned p;
    p = $urandom_range(0, 19);
    if (p == 0) return '0;
    if (p == 1) return MAX_T;
    if (p == 2) return rand62();
    return TIME_W'($urandom_range(0, 10000)) * ONE_MS + TIME_W'($urandom_range(0, 999999));
  endfunction

  // Next random request: mostly a plausible idle timeline, some pure noise
  function automatic stim_row_t next_rand_req();
    logic [TIME_W-1:0] step;
    int unsigned       p;
    p = $urandom_range(0, 99);
    if (p < 15) begin
      return mk_req(its_req_e'($urandom_range(0, 1)), rand62(), rand62(),
                    1'($urandom), 4'($urandom), 1'b0, '0, '0);
    end
    if (p < 23) begin
      tl_now   = TIME_W'($urandom) * 1000;
      tl_input = tl_now;
      return mk_req(REQ_START, tl_now, rand62(), 1'($urandom), 4'($urandom), 1'b0, '0, '0);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: step = TIME_W'($urandom_range(0, 50000000));
      5, 6, 7, 8:    step = TIME_W'($urandom_range(0, 3000)) * ONE_MS;
      default:       step = TIME_W'($urandom_range(0, 20000)) * ONE_MS;
    endcase
    tl_now = tl_now + step;
    // Fresh user input somewhere inside the last step
    if ($urandom_range(0, 9) < 3)
      tl_input = tl_now - (step * $urandom_range(0, 100)) / 100;
    return mk_req(REQ_EVAL, tl_now, tl_now - tl_input, $urandom_range(0, 9) == 0,
                  ($urandom_range(0, 9) < 7) ? 4'd0 : 4'($urandom), 1'b0, '0, '0);
  endfunction

  // Response side: random backpressure, checked at the rising edge
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      automatic int unsigned n = gap_len();
      rsp_ch.ready <= (n == 0);
      stall_left   <= (n == 0) ? 0 : n - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_out.size() == 0) begin
        $display("%0t: response beat with nothing owed: fire %h timeout %0d",
                 $time, rsp_ch.fire_mask, rsp_ch.timeout_ns);
        err_count++;
      end else begin
        automatic sched_out_t exp_out = pending_out.pop_front();
        n_checked++;
        if (exp_out.fire != 0) n_fired++;
        if (rsp_ch.fire_mask !== exp_out.fire) begin
          $display("%0t: fire_mask expected %h got %h", $time, exp_out.fire, rsp_ch.fire_mask);
          err_count++;
        end
        if (rsp_ch.timeout_ns !== exp_out.tmo) begin
          $display("%0t: timeout_ns expected %0d got %0d",
                   $time, exp_out.tmo, rsp_ch.timeout_ns);
          err_count++;
        end
      end
    end
  end

  initial begin
    // Known values on every input from time zero
    rst_ni              = 1'b0;
    cyc                 = 0;
    stall_left          = 0;
    calm                = 1'b0;
    err_count           = 0;
    n_items             = 0;
    n_fired             = 0;
    n_checked           = 0;
    n_cfg               = 0;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_START;
    req_ch.now_ns       = '0;
    req_ch.idle_ns      = '0;
    req_ch.busy_req     = 1'b0;
    req_ch.running_mask = '0;
    rsp_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_ACTION_COUNT;
    cfg_ch.data         = '0;
    act_count           = '0;
    for (int i = 0; i < SLOTS; i++) dly[i] = '0;
    win_start           = '0;
    origin              = '0;
    prev_activity       = '0;
    tl_now              = '0;
    tl_input            = '0;

    // Directed table. Reset state, no actions: evaluate before any start,
    // then a start and a busy evaluate at the top of the time range.
    dir_tab.push_back(mk_req(REQ_EVAL, '0, '0, 1'b0, 4'h0, 1'b1, 4'h0, YEAR_NS));
    dir_tab.push_back(mk_req(REQ_START, MAX_T, MAX_T, 1'b1, 4'hf, 1'b1, 4'h0, '0));
    dir_tab.push_back(mk_req(REQ_EVAL, MAX_T, MAX_T, 1'b1, 4'hf, 1'b1, 4'h0, YEAR_NS));
    // Four actions: zero delay, one second, five seconds, the largest delay
    dir_tab.push_back(mk_cfg(REG_ACTION_COUNT, 62'd4));
    dir_tab.push_back(mk_cfg(REG_DELAY_0, '0));
    dir_tab.push_back(mk_cfg(REG_DELAY_1, ONE_S));
    dir_tab.push_back(mk_cfg(REG_DELAY_2, 5 * ONE_S));
    dir_tab.push_back(mk_cfg(REG_DELAY_3, MAX_T));
    dir_tab.push_back(mk_req(REQ_START, '0, '0, 1'b0, 4'h0, 1'b1, 4'h0, '0));
    dir_tab.push_back(mk_req(REQ_EVAL, '0, '0, 1'b0, 4'h0, 1'b0, '0, '0));
    dir_tab.push_back(mk_req(REQ_EVAL, ONE_S, ONE_S, 1'b0, 4'h0, 1'b0, '0, '0));
    dir_tab.push_back(mk_req(REQ_EVAL, 2 * ONE_S, 2 * ONE_S, 1'b0, 4'h2, 1'b0, '0, '0));
    dir_tab.push_back(mk_req(REQ_EVAL, 8 * ONE_S, 8 * ONE_S, 1'b1, 4'h0, 1'b0, '0, '0));
    // Idle longer than the clock has run: activity lands before zero
    dir_tab.push_back(mk_req(REQ_EVAL, 9 * ONE_S, MAX_T, 1'b0, 4'h0, 1'b0, '0, '0));
    dir_tab.push_back(mk_req(REQ_EVAL, MAX_T, '0, 1'b0, 4'hf, 1'b0, '0, '0));
    // Count above the cap, delays around the 10 ms floor
    dir_tab.push_back(mk_cfg(REG_ACTION_COUNT, 62'd7));
    dir_tab.push_back(mk_cfg(REG_DELAY_0, MAX_T));
    dir_tab.push_back(mk_cfg(REG_DELAY_1, 62'd1));
    dir_tab.push_back(mk_cfg(REG_DELAY_2, 10 * ONE_MS));
    dir_tab.push_back(mk_cfg(REG_DELAY_3, 10 * ONE_MS - 1));
    dir_tab.push_back(mk_req(REQ_START, 62'd1000, '0, 1'b0, 4'h0, 1'b1, 4'h0, '0));
    dir_tab.push_back(mk_req(REQ_EVAL, 62'd1000 + 10 * ONE_MS - 1, 10 * ONE_MS - 1,
                             1'b0, 4'h0, 1'b0, '0, '0));
    dir_tab.push_back(mk_req(REQ_EVAL, 62'd1000 + 20 * ONE_MS, 20 * ONE_MS,
                             1'b0, 4'h0, 1'b0, '0, '0));
    dir_tab.push_back(mk_req(REQ_EVAL, 62'd1000 + 25 * ONE_MS, '0, 1'b0, 4'h0, 1'b0, '0, '0));
    // New activity past the 10 ms gap re-bases the timeline
    dir_tab.push_back(mk_req(REQ_EVAL, 62'd1000 + 40 * ONE_MS, '0, 1'b0, 4'h0, 1'b0, '0, '0));
    dir_tab.push_back(mk_req(REQ_EVAL, 62'd1000 + 50 * ONE_MS, 10 * ONE_MS, 1'b1, 4'hf,
                             1'b0, '0, '0));
    // Single action, then none
    dir_tab.push_back(mk_cfg(REG_ACTION_COUNT, 62'd1));
    dir_tab.push_back(mk_cfg(REG_DELAY_0, 3 * ONE_S));
    dir_tab.push_back(mk_req(REQ_START, '0, '0, 1'b0, 4'h0, 1'b1, 4'h0, '0));
    dir_tab.push_back(mk_req(REQ_EVAL, 3 * ONE_S, 3 * ONE_S, 1'b0, 4'he, 1'b0, '0, '0));
    dir_tab.push_back(mk_req(REQ_EVAL, 4 * ONE_S, ONE_S, 1'b0, 4'h1, 1'b0, '0, '0));
    dir_tab.push_back(mk_cfg(REG_ACTION_COUNT, 62'd0));
    dir_tab.push_back(mk_req(REQ_EVAL, 5 * ONE_S, 5 * ONE_S, 1'b0, 4'hf, 1'b1, 4'h0, YEAR_NS));

    // Hold reset, release on a falling edge
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Walk the table; config rows wait for the block to go idle
    foreach (dir_tab[k]) begin
      if (dir_tab[k].kind == ROW_CFG) begin
        if (k == 0 || dir_tab[k-1].kind != ROW_CFG) drain_results();
        write_reg(dir_tab[k].reg_idx, dir_tab[k].data);
      end else begin
        send_req(dir_tab[k]);
      end
    end

    // Random phases: fresh config each time, every few phases without idling
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results();
      calm = (ph % 3 == 2);
      write_reg(REG_ACTION_COUNT,
                ($urandom_range(0, 1) == 0) ? 62'd4 : TIME_W'($urandom_range(0, 7)));
      write_reg(REG_DELAY_0, rand_delay());
      write_reg(REG_DELAY_1, rand_delay());
      write_reg(REG_DELAY_2, rand_delay());
      write_reg(REG_DELAY_3, rand_delay());
      // Open each phase on a clean timeline
      tl_now   = TIME_W'($urandom) * 1000;
      tl_input = tl_now;
      send_req(mk_req(REQ_START, tl_now, '0, 1'b0, 4'h0, 1'b0, '0, '0));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Now and then hold off until the block has answered everything
        if ($urandom_range(0, 39) == 0) drain_results();
        send_req(next_rand_req());
      end
    end

    drain_results();
    $display("Sent %0d requests over %0d register writes; %0d responses checked,",
             n_items, n_cfg, n_checked);
    $display("%0d of them firing actions; %0d mismatches", n_fired, err_count);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
